// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the stencil core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TWLS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property must never hold at a clock edge outside reset
`define TWLS_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// ===== hw/rtl/twls_pkg.sv =====
package twls_pkg;

	// default sizes
	localparam int MAX_LEVEL_DEF        = 12;
	localparam int SAMPLE_WIDTH_DEF     = 24;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;

	// grid level register width, fixed by the register map
	localparam int LEVEL_W = 4;

	// register map
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_GRID_LEVEL   = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_RIGHT_WEIGHT = 1'd1;

	// reset value of the grid level register
	localparam logic [LEVEL_W-1:0] GRID_LEVEL_RESET = 4'd1;

	// result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	// stencil form of a grid point
	typedef enum logic [1:0] {
		KIND_ENDPOINT,
		KIND_LEFT,
		KIND_RIGHT
	} twls_kind_t;

	// index status handed from the digit counter to the datapath
	typedef struct packed {
		logic       started;
		twls_kind_t kind;
		logic       last;
	} twls_info_t;

endpackage

// ===== hw/rtl/twls_index.sv =====
module twls_index #(
	parameter int MAX_LEVEL = twls_pkg::MAX_LEVEL_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [twls_pkg::LEVEL_W-1:0] grid_level,
	input  logic                         restart,
	input  logic                         step,
	output twls_pkg::twls_info_t         info
);

	logic       started_q;
	logic [1:0] trits_q [MAX_LEVEL];
	logic [1:0] trits_inc [MAX_LEVEL];
	logic       all_zero;
	logic       all_two;
	logic [1:0] low_trit;
	logic       carry;

	// classify the current index k from its base-3 digits
	always_comb begin
		all_zero = 1'b1;
		all_two  = 1'b1;
		low_trit = 2'd0;
		carry    = 1'b1;
		for (int d = 0; d < MAX_LEVEL; d++) begin
			if (trits_q[d] != 2'd0) begin
				all_zero = 1'b0;
			end
			if ((d < int'(grid_level)) && (trits_q[d] != 2'd2)) begin
				all_two = 1'b0;
			end
			if (carry) begin
				trits_inc[d] = (trits_q[d] == 2'd2) ? 2'd0 : trits_q[d] + 2'd1;
			end else begin
				trits_inc[d] = trits_q[d];
			end
			carry = carry && (trits_q[d] == 2'd2);
		end
		for (int d = MAX_LEVEL - 1; d >= 0; d--) begin
			if (trits_q[d] != 2'd0) begin
				low_trit = trits_q[d];
			end
		end
	end

	// status toward the datapath
	always_comb begin
		info.started = started_q;
		info.last    = all_two;
		if (all_zero) begin
			info.kind = twls_pkg::KIND_ENDPOINT;
		end else if (low_trit == 2'd1) begin
			info.kind = twls_pkg::KIND_LEFT;
		end else begin
			info.kind = twls_pkg::KIND_RIGHT;
		end
	end

	// digit counter, restarts on a level write and after the final sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			for (int d = 0; d < MAX_LEVEL; d++) begin
				trits_q[d] <= 2'd0;
			end
		end else if (restart) begin
			started_q <= 1'b0;
			for (int d = 0; d < MAX_LEVEL; d++) begin
				trits_q[d] <= 2'd0;
			end
		end else if (step) begin
			if (!started_q) begin
				started_q <= 1'b1;
				for (int d = 0; d < MAX_LEVEL; d++) begin
					trits_q[d] <= 2'd0;
				end
			end else if (all_two) begin
				started_q <= 1'b0;
				for (int d = 0; d < MAX_LEVEL; d++) begin
					trits_q[d] <= 2'd0;
				end
			end else begin
				for (int d = 0; d < MAX_LEVEL; d++) begin
					trits_q[d] <= trits_inc[d];
				end
			end
		end
	end

endmodule

// ===== hw/rtl/twls_queue.sv =====
module twls_queue #(
	parameter int DATA_W = twls_pkg::SAMPLE_WIDTH_DEF + 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_a,
	input  logic [DATA_W-1:0] data_a,
	input  logic              push_b,
	input  logic [DATA_W-1:0] data_b,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] out_data
);

	localparam int PW = twls_pkg::QUEUE_PTR_W;

	logic [DATA_W-1:0] mem_q [twls_pkg::QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;
	logic              pop;
	logic [PW:0]       push_n;

	// room for two entries, enough for the final sample of a block
	assign room      = count_q <= (PW + 1)'(twls_pkg::QUEUE_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign push_n    = (PW + 1)'(push_a) + (PW + 1)'(push_b);

	// entry storage
	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_ptr_q] <= data_a;
		end
		if (push_b) begin
			mem_q[wr_ptr_q + PW'(1)] <= data_b;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[PW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + push_n - (PW + 1)'(pop);
		end
	end

endmodule

// ===== hw/rtl/triadic_weighted_laplacian_stencil_core.sv =====
// Takes one sample per clock whenever the result queue has two free entries, which it has
// in steady state, so a block of 3^L+1 samples streams through at one sample a cycle. The
// result for point k, after sample k+1 is taken, goes through the input register, product
// register and queue, and the final sample of a block puts two results into the four-entry
// queue at once; sample_stall rises only while that queue holds more than two results.
// The two weighted products are formed in parallel in one stage, one multiplier each.
// Write grid_level or right_weight only while the block is idle; a grid_level write
// starts a new block.
`include "assert_macros.svh"

module triadic_weighted_laplacian_stencil_core #(
	parameter int MAX_LEVEL        = twls_pkg::MAX_LEVEL_DEF,
	parameter int SAMPLE_WIDTH     = twls_pkg::SAMPLE_WIDTH_DEF,
	parameter int WEIGHT_FRAC_BITS = twls_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [twls_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [WEIGHT_FRAC_BITS:0]      cfg_data,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic signed [SAMPLE_WIDTH+1:0] laplacian_value,
	output logic                           block_end
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int F  = WEIGHT_FRAC_BITS;
	localparam int WW = F + 1;
	localparam int PW = SW + F + 2;
	localparam int OW = SW + 2;
	localparam logic [WW-1:0] WEIGHT_ONE  = WW'(1) << F;
	localparam logic [WW-1:0] WEIGHT_HALF = WW'(1) << (F - 1);
	localparam logic [PW-1:0] ROUND_HALF  = PW'(1) << (F - 1);

	// configuration registers
	logic [twls_pkg::LEVEL_W-1:0] grid_level_q;
	logic [WW-1:0]                right_weight_q;
	logic                         level_write;

	// sample history
	logic signed [SW-1:0] newest_q;
	logic signed [SW-1:0] older_q;

	// handshake
	logic                 adv;
	logic                 accept;
	twls_pkg::twls_info_t info;

	// weights and operand selection
	logic [WW-1:0]        p_eff;
	logic [WW-1:0]        q_eff;
	logic signed [SW-1:0] a_sel;
	logic signed [SW-1:0] b_sel;
	logic [WW-1:0]        wa_sel;
	logic [WW-1:0]        wb_sel;

	// stage 1: operands
	logic                 valid_s1;
	logic                 end_s1;
	logic signed [SW-1:0] a_s1;
	logic signed [SW-1:0] b_s1;
	logic [WW-1:0]        wa_s1;
	logic [WW-1:0]        wb_s1;
	logic signed [SW-1:0] newest_s1;
	logic signed [SW-1:0] x_s1;

	// products
	logic signed [PW-1:0] prod_a;
	logic signed [PW-1:0] prod_b;
	logic signed [PW-1:0] sum_a;
	logic signed [PW-1:0] sum_b;

	// stage 2: rounded terms
	logic                 valid_s2;
	logic                 end_s2;
	logic signed [SW:0]   ta_s2;
	logic signed [SW:0]   tb_s2;
	logic signed [SW-1:0] newest_s2;
	logic signed [SW-1:0] x_s2;

	// results into the queue
	logic signed [OW-1:0] interior_r;
	logic signed [OW-1:0] endpoint_r;
	logic [OW:0]          q_data_a;
	logic [OW:0]          q_data_b;
	logic [OW:0]          q_out;

	// register writes
	assign level_write = cfg_write && (cfg_index == twls_pkg::REG_GRID_LEVEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_level_q   <= twls_pkg::GRID_LEVEL_RESET;
			right_weight_q <= WEIGHT_HALF;
		end else if (cfg_write) begin
			unique case (cfg_index)
				twls_pkg::REG_GRID_LEVEL: begin
					grid_level_q <= cfg_data[twls_pkg::LEVEL_W-1:0];
				end
				twls_pkg::REG_RIGHT_WEIGHT: begin
					right_weight_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// index tracking
	twls_index #(
		.MAX_LEVEL(MAX_LEVEL)
	) u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_level(grid_level_q),
		.restart   (level_write),
		.step      (accept),
		.info      (info)
	);

	// transfer control: the whole pipe moves when the queue can take two results
	assign sample_stall = !adv;
	assign accept       = sample_valid && adv;

	// clamp weight to one, left weight is the complement
	assign p_eff = (right_weight_q > WEIGHT_ONE) ? WEIGHT_ONE : right_weight_q;
	assign q_eff = WEIGHT_ONE - p_eff;

	// pick operands per stencil form; an endpoint is x weighted by one
	always_comb begin
		case (info.kind)
			twls_pkg::KIND_LEFT: begin
				a_sel  = older_q;
				wa_sel = q_eff;
				b_sel  = sample_value;
				wb_sel = p_eff;
			end
			twls_pkg::KIND_RIGHT: begin
				a_sel  = sample_value;
				wa_sel = q_eff;
				b_sel  = older_q;
				wb_sel = p_eff;
			end
			default: begin
				a_sel  = sample_value;
				wa_sel = '0;
				b_sel  = sample_value;
				wb_sel = WEIGHT_ONE;
			end
		endcase
	end

	// sample history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			older_q  <= '0;
		end else if (accept) begin
			older_q  <= newest_q;
			newest_q <= sample_value;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept && info.started;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			end_s1    <= info.last;
			a_s1      <= a_sel;
			b_s1      <= b_sel;
			wa_s1     <= wa_sel;
			wb_s1     <= wb_sel;
			newest_s1 <= newest_q;
			x_s1      <= sample_value;
		end
	end

	// weighted products, rounded half up
	assign prod_a = $signed({{(F + 2){a_s1[SW-1]}}, a_s1}) * $signed({{(SW + 1){1'b0}}, wa_s1});
	assign prod_b = $signed({{(F + 2){b_s1[SW-1]}}, b_s1}) * $signed({{(SW + 1){1'b0}}, wb_s1});
	assign sum_a  = prod_a + ROUND_HALF;
	assign sum_b  = prod_b + ROUND_HALF;

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			end_s2    <= end_s1;
			ta_s2     <= sum_a[F+SW:F];
			tb_s2     <= sum_b[F+SW:F];
			newest_s2 <= newest_s1;
			x_s2      <= x_s1;
		end
	end

	// final differences
	assign interior_r = OW'(newest_s2) - OW'(ta_s2) - OW'(tb_s2);
	assign endpoint_r = OW'(x_s2) - OW'(newest_s2);
	assign q_data_a   = {1'b0, interior_r};
	assign q_data_b   = {1'b1, endpoint_r};

	// result queue
	twls_queue #(
		.DATA_W(OW + 1)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_a   (adv && valid_s2),
		.data_a   (q_data_a),
		.push_b   (adv && valid_s2 && end_s2),
		.data_b   (q_data_b),
		.room     (adv),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.out_data (q_out)
	);

	assign block_end       = q_out[OW];
	assign laplacian_value = q_out[OW-1:0];

	// checks
	`TWLS_ASSERT(a_last_marks_end, clk, arst_n, accept && !cfg_write && info.started && info.last |=> valid_s1 && end_s1, "final sample did not mark block end")
	`TWLS_ASSERT(a_weights_sum_one, clk, arst_n, valid_s1 |-> (({1'b0, wa_s1} + {1'b0, wb_s1}) == {1'b0, WEIGHT_ONE}), "stencil weights do not sum to one")
	`TWLS_ASSERT(a_s2_holds, clk, arst_n, valid_s2 && sample_stall |=> valid_s2 && $stable(ta_s2) && $stable(tb_s2), "stage 2 changed while stalled")

endmodule
